>>> src/pida_pkg.sv
// ----------------------------------------------------------------------------
// pida_pkg
// Shared types and constants for the positional insert/delete array.
// ----------------------------------------------------------------------------
package pida_pkg;

   localparam int CAPACITY = 64;
   localparam int WORD_W   = 32;
   localparam int POS_W    = 7;
   localparam int CNT_OUT_W = 7;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   // width used for position against count compares
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [1:0] {
      ACT_PUSH   = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_DELETE = 2'd2,
      ACT_READ   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD       = 2'd0,
      CELL_TAKE_LOWER = 2'd1,
      CELL_TAKE_UPPER = 2'd2,
      CELL_LOAD       = 2'd3
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type cmd;
      logic         rd_sel;
   } cell_ctrl_type;

endpackage

>>> src/pida_cell.sv
// ----------------------------------------------------------------------------
// pida_cell
// One storage cell of the array: holds a word, takes it from a neighbour
// or from the request, and offers it to the read bus when selected.
// ----------------------------------------------------------------------------
module pida_cell
   import pida_pkg::*;
(
   input  logic                     clock,
   input  cell_ctrl_type            ctrl,
   input  logic signed [WORD_W-1:0] lower_word,
   input  logic signed [WORD_W-1:0] upper_word,
   input  logic signed [WORD_W-1:0] new_word,
   output logic signed [WORD_W-1:0] cell_word,
   output logic signed [WORD_W-1:0] rd_word
);

   logic signed [WORD_W-1:0] data_ff;
   logic signed [WORD_W-1:0] data_in;

   always_comb begin
      unique case (ctrl.cmd)
         CELL_HOLD:       data_in = data_ff;
         CELL_TAKE_LOWER: data_in = lower_word;
         CELL_TAKE_UPPER: data_in = upper_word;
         CELL_LOAD:       data_in = new_word;
         default:         data_in = data_ff;
      endcase
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign cell_word = data_ff;
   assign rd_word   = ctrl.rd_sel ? data_ff : '0;

endmodule

>>> src/positional_insert_delete_array.sv
// ----------------------------------------------------------------------------
// positional_insert_delete_array
// Ordered array of signed words with push, insert, delete and read.
// ----------------------------------------------------------------------------
// Usage:
//   A request word (req_action, req_position, req_value) is taken at a rising
//   edge where start is high and busy is low. busy never rises, so one word
//   can be taken in every cycle.
//   Every request gives exactly one response word, shown on the rsp_ ports
//   for one cycle with rsp_valid high, in the cycle after the request was
//   taken; throughput is 1 word per cycle.
//   The data sits in a row of cells; on insert or delete each cell compares
//   its place with the position, and the cells that move take their
//   neighbour's word or the new word in the same edge. A read selects one
//   cell onto an and-or bus that is registered into the response.
//   The receiver has no way to stall; a response not taken is lost.
//   Reset clears the element count and the response strobe; cell contents
//   are undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
module positional_insert_delete_array
   import pida_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_action,
   input  logic [POS_W-1:0]            req_position,
   input  logic signed [WORD_W-1:0]    req_value,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic [CNT_OUT_W-1:0]        rsp_count_after,
   output logic signed [WORD_W-1:0]    rsp_read_value
);

   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic [CNT_OUT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic signed [WORD_W-1:0]  rsp_read_ff, rsp_read_in;

   action_type                act;
   logic                      accept;
   logic [CMP_W-1:0]          pos_ext, cnt_ext, ins_pos;
   logic                      full, ins_go, del_go, rd_go;
   logic signed [WORD_W-1:0]  rd_bus;

   cell_ctrl_type             ctrl      [CAPACITY];
   logic signed [WORD_W-1:0]  cell_word [CAPACITY];
   logic signed [WORD_W-1:0]  rd_word   [CAPACITY];

   assign busy    = 1'b0;
   assign accept  = start && !busy;
   assign act     = action_type'(req_action);
   assign pos_ext = CMP_W'(req_position);
   assign cnt_ext = CMP_W'(count_ff);
   assign full    = (count_ff == CNT_W'(CAPACITY));

   // request decode and status
   always_comb begin
      ins_go        = 1'b0;
      del_go        = 1'b0;
      rd_go         = 1'b0;
      ins_pos       = pos_ext;
      rsp_status_in = ST_OK;
      unique case (act)
         ACT_PUSH: begin
            ins_pos = cnt_ext;
            if (full) rsp_status_in = ST_FULL;
            else      ins_go = accept;
         end
         ACT_INSERT: begin
            if (pos_ext > cnt_ext) rsp_status_in = ST_RANGE;
            else if (full)         rsp_status_in = ST_FULL;
            else                   ins_go = accept;
         end
         ACT_DELETE: begin
            if (pos_ext >= cnt_ext) rsp_status_in = ST_RANGE;
            else                    del_go = accept;
         end
         ACT_READ: begin
            if (pos_ext >= cnt_ext) rsp_status_in = ST_RANGE;
            else                    rd_go = 1'b1;
         end
         default: rsp_status_in = ST_OK;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (ins_go)      count_in = count_ff + CNT_W'(1);
      else if (del_go) count_in = count_ff - CNT_W'(1);
   end

   // row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [WORD_W-1:0] lower_word, upper_word;

      if (i == 0) begin : g_first
         assign lower_word = '0;
      end else begin : g_lower
         assign lower_word = cell_word[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign upper_word = cell_word[i];
      end else begin : g_upper
         assign upper_word = cell_word[i+1];
      end

      always_comb begin
         ctrl[i].rd_sel = (pos_ext == CMP_W'(i));
         priority if (ins_go && (CMP_W'(i) > ins_pos))
            ctrl[i].cmd = CELL_TAKE_LOWER;
         else if (ins_go && (CMP_W'(i) == ins_pos))
            ctrl[i].cmd = CELL_LOAD;
         else if (del_go && (CMP_W'(i) >= pos_ext))
            ctrl[i].cmd = CELL_TAKE_UPPER;
         else
            ctrl[i].cmd = CELL_HOLD;
      end

      pida_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl[i]),
         .lower_word (lower_word),
         .upper_word (upper_word),
         .new_word   (req_value),
         .cell_word  (cell_word[i]),
         .rd_word    (rd_word[i])
      );
   end

   // and-or read bus, at most one cell selected
   always_comb begin
      rd_bus = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         rd_bus = rd_bus | rd_word[k];
      end
   end

   assign rsp_valid_in = accept;
   assign rsp_count_in = CNT_OUT_W'(count_in);
   assign rsp_read_in  = rd_go ? rd_bus : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_read_ff   <= rsp_read_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_count_after = rsp_count_ff;
   assign rsp_read_value  = rsp_read_ff;

   // assertions
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   a_one_response: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted word gave no response");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |->
         rsp_count_after == CNT_OUT_W'(CAPACITY))
      else $error("full status while array not full");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      accept |=> (count_ff == $past(count_ff) ||
                  count_ff == $past(count_ff) + CNT_W'(1) ||
                  count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("element count moved by more than one");

endmodule
